FILE: rtl/mrgq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrgq_pkg: shared types and constants for the range GCD query block
// Sizes of the cell store, field widths, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package mrgq_pkg;

	localparam int MAX_SIDE = 64;
	localparam int IDX_W    = $clog2(MAX_SIDE);
	localparam int ADDR_W   = 2 * IDX_W;
	localparam int DEPTH    = MAX_SIDE * MAX_SIDE;
	localparam int VAL_W    = 31;
	localparam int K_W      = $clog2(VAL_W);
	localparam int SIDE_W   = IDX_W + 1;

	localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(MAX_SIDE);
	localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);
	localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(1);

	// register index decoded from paddr[2]
	localparam logic REG_SIDE = 1'b0;

	// input kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_STEP
	} state_t;

endpackage

FILE: rtl/matrix_range_gcd_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_range_gcd_query: GCD over a rectangle of a loaded square matrix
// Cells are loaded one at a time into a 4096-entry store; a query walks the
// clipped rectangle cell by cell and folds each cell into a running GCD.
// ----------------------------------------------------------------------------
// A load (kind 0) is written into the store from idle and busy never rises for
// it. A query (kind 1) over a non-empty rectangle raises busy until its result
// is shown on done for one cycle, with busy already low in that cycle; the
// receiver cannot hold a result off. An empty rectangle is answered in the
// cycle after start and never raises busy. Otherwise each cell takes a store
// read (states READ and LOAD) plus the steps of the shared binary GCD unit,
// one compare-subtract-shift per cycle, until one operand is zero. The store
// needs no clearing pass; a cell must be loaded before a query covers it.
module matrix_range_gcd_query (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [mrgq_pkg::VAL_W-1:0]    value,
	input  logic [mrgq_pkg::IDX_W-1:0]    left,
	input  logic [mrgq_pkg::IDX_W-1:0]    right,
	input  logic [mrgq_pkg::IDX_W-1:0]    top,
	input  logic [mrgq_pkg::IDX_W-1:0]    bottom,
	// result channel
	output logic                          done,
	output logic [mrgq_pkg::VAL_W-1:0]    gcd,
	output logic                          empty_res,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import mrgq_pkg::*;

	state_t state_q, state_d;

	logic [SIDE_W-1:0] side_q;
	logic [VAL_W-1:0]  mem [DEPTH];
	logic [VAL_W-1:0]  rdata_q;

	logic [IDX_W-1:0]  row_q, col_q;
	logic [IDX_W-1:0]  left_q, right_q, bottom_q;
	logic [VAL_W-1:0]  acc_q;
	logic [VAL_W-1:0]  ga_q, gb_q;
	logic [K_W-1:0]    gk_q;

	logic              done_q, empty_q;
	logic [VAL_W-1:0]  gcd_q;

	// derived controls
	logic              cfg_wr;
	logic              wr_en;
	logic              q_start;
	logic              q_empty;
	logic              last_cell;
	logic              step_fin;

	logic [SIDE_W-1:0] side_use;
	logic [IDX_W-1:0]  side_m1;
	logic [IDX_W-1:0]  right_c, bottom_c;

	logic [VAL_W-1:0]  fin_val, fin_res;
	logic [VAL_W-1:0]  a_min_b, b_min_a;
	logic              a_ge_b;

	// APB register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SIDE);
	assign prdata = (paddr[2] == REG_SIDE) ? {{(32-SIDE_W){1'b0}}, side_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
		end else if (cfg_wr) begin
			side_q <= pwdata[SIDE_W-1:0];
		end
	end

	// clip the rectangle to the side in use
	always_comb begin
		if (side_q < SIDE_MIN) begin
			side_use = SIDE_MIN;
		end else if (side_q > SIDE_MAX) begin
			side_use = SIDE_MAX;
		end else begin
			side_use = side_q;
		end
		side_m1  = IDX_W'(side_use - SIDE_MIN);
		right_c  = (right > side_m1) ? side_m1 : right;
		bottom_c = (bottom > side_m1) ? side_m1 : bottom;
	end

	// binary GCD step: one compare-subtract-shift per cycle
	always_comb begin
		a_min_b  = ga_q - gb_q;
		b_min_a  = gb_q - ga_q;
		a_ge_b   = (ga_q >= gb_q);
		fin_val  = (ga_q == '0) ? gb_q : ga_q;
		fin_res  = fin_val << gk_q;
		step_fin = (ga_q == '0) || (gb_q == '0);
	end

	assign last_cell = (col_q == right_q) && (row_q == bottom_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_start && !q_empty) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_STEP;
			end
			ST_STEP: begin
				if (step_fin) begin
					state_d = last_cell ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		busy    = 1'b1;
		wr_en   = 1'b0;
		q_start = 1'b0;
		q_empty = (left > right_c) || (top > bottom_c);
		unique case (state_q)
			ST_IDLE: begin
				busy    = 1'b0;
				wr_en   = start && (kind == KIND_LOAD);
				q_start = start && (kind == KIND_QUERY);
			end
			ST_READ, ST_LOAD, ST_STEP: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// cell store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[{top, left}] <= value;
		end
		rdata_q <= mem[{row_q, col_q}];
	end

	// walk the rectangle and fold cells into the running GCD
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				row_q    <= top;
				col_q    <= left;
				left_q   <= left;
				right_q  <= right_c;
				bottom_q <= bottom_c;
				acc_q    <= '0;
			end
			ST_LOAD: begin
				ga_q <= acc_q;
				gb_q <= rdata_q;
				gk_q <= '0;
			end
			ST_STEP: begin
				if (step_fin) begin
					acc_q <= fin_res;
					if (col_q == right_q) begin
						col_q <= left_q;
						row_q <= row_q + IDX_W'(1);
					end else begin
						col_q <= col_q + IDX_W'(1);
					end
				end else if (!ga_q[0] && !gb_q[0]) begin
					ga_q <= ga_q >> 1;
					gb_q <= gb_q >> 1;
					gk_q <= gk_q + K_W'(1);
				end else if (!ga_q[0]) begin
					ga_q <= ga_q >> 1;
				end else if (!gb_q[0]) begin
					gb_q <= gb_q >> 1;
				end else if (a_ge_b) begin
					ga_q <= a_min_b >> 1;
				end else begin
					gb_q <= b_min_a >> 1;
				end
			end
			default: begin
			end
		endcase
	end

	// result beat: one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q  <= 1'b0;
			empty_q <= 1'b0;
			gcd_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (q_start && q_empty) begin
				done_q  <= 1'b1;
				empty_q <= 1'b1;
				gcd_q   <= '0;
			end else if ((state_q == ST_STEP) && step_fin && last_cell) begin
				done_q  <= 1'b1;
				empty_q <= 1'b0;
				gcd_q   <= fin_res;
			end
		end
	end

	assign done      = done_q;
	assign gcd       = gcd_q;
	assign empty_res = empty_q;

endmodule

FILE: tb/matrix_range_gcd_query_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_range_gcd_query_tb: self-checking bench for the range GCD query block
// Loads cells and fires rectangle queries through the command port. It keeps a
// private copy of the matrix and the side, works out the GCD or empty flag of
// every accepted query, and compares each result beat against the oldest
// pending answer. The side register is rewritten over APB between phases, and
// the sender idles at different rates from phase to phase.
// ----------------------------------------------------------------------------
module matrix_range_gcd_query_tb;
	import mrgq_pkg::*;

	localparam int WATCH_LIMIT = 60000;
	localparam int PHASES      = 11;
	localparam int ITEMS       = 580;
	localparam logic [VAL_W-1:0] VAL_TOP = '1;

	typedef struct {
		logic             kind;
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic [IDX_W-1:0] top;
		logic [IDX_W-1:0] bottom;
		bit               hold;
	} cmd_t;

	typedef struct {
		logic [VAL_W-1:0] gcd;
		logic             is_empty;
	} answer_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             start     = 1'b0;
	logic             busy;
	logic             kind      = KIND_LOAD;
	logic [VAL_W-1:0] value     = '0;
	logic [IDX_W-1:0] left      = '0;
	logic [IDX_W-1:0] right     = '0;
	logic [IDX_W-1:0] top       = '0;
	logic [IDX_W-1:0] bottom    = '0;
	logic             done;
	logic [VAL_W-1:0] gcd;
	logic             empty_res;
	logic             psel      = 1'b0;
	logic             penable   = 1'b0;
	logic             pwrite    = 1'b0;
	logic [2:0]       paddr     = '0;
	logic [31:0]      pwdata    = '0;
	logic [31:0]      prdata;
	logic             pready;

	cmd_t             pending_cmds[$];
	answer_t          awaited_gcds[$];
	logic [VAL_W-1:0] cell_copy[DEPTH];
	logic [SIDE_W-1:0] side_copy = SIDE_RESET;
	bit               was_loaded[DEPTH];
	int               gen_side  = MAX_SIDE;
	int               idle_pct  = 0;
	int               queued    = 0;
	int               fails     = 0;
	int               quiet     = 0;
	logic             taken     = 1'b0;

	int side_plan[PHASES] = '{64, 1, 0, 127, 8, 65, 2, -1, 64, 100, 5};
	int idle_plan[3]      = '{0, 67, 9};

	matrix_range_gcd_query DUT (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .kind(kind), .value(value),
		.left(left), .right(right), .top(top), .bottom(bottom),
		.done(done), .gcd(gcd), .empty_res(empty_res),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [VAL_W-1:0] euclid(input logic [VAL_W-1:0] a,
			input logic [VAL_W-1:0] b);
		logic [VAL_W-1:0] x, y, r;
		x = a;
		y = b;
		while (y != '0) begin
			r = x % y;
			x = y;
			y = r;
		end
		return x;
	endfunction

	function automatic int side_eff(input int s);
		if (s < 1) return 1;
		if (s > MAX_SIDE) return MAX_SIDE;
		return s;
	endfunction

	// Store a load, or fold the clipped rectangle into one awaited answer
	function automatic void apply_cmd(input cmd_t c);
		int eff, rgt, bot, row, col;
		answer_t ans;
		if (c.kind == KIND_LOAD) begin
			cell_copy[{c.top, c.left}] = c.value;
		end else begin
			eff = side_eff(int'(side_copy));
			rgt = (int'(c.right) > eff - 1) ? eff - 1 : int'(c.right);
			bot = (int'(c.bottom) > eff - 1) ? eff - 1 : int'(c.bottom);
			ans.gcd = '0;
			ans.is_empty = 1'b0;
			if (int'(c.left) > rgt || int'(c.top) > bot) begin
				ans.is_empty = 1'b1;
			end else begin
				for (row = int'(c.top); row <= bot; row++)
					for (col = int'(c.left); col <= rgt; col++)
						ans.gcd = euclid(ans.gcd, cell_copy[row * MAX_SIDE + col]);
			end
			awaited_gcds.insert(awaited_gcds.size(), ans);
		end
	endfunction

	// ---------------------------------------------------------------- generator

	function automatic void push_cmd(input logic k, input logic [VAL_W-1:0] v,
			input int l, input int r, input int t, input int b, input bit hold);
		cmd_t c;
		c.kind   = k;
		c.value  = v;
		c.left   = IDX_W'(l);
		c.right  = IDX_W'(r);
		c.top    = IDX_W'(t);
		c.bottom = IDX_W'(b);
		c.hold   = hold;
		pending_cmds.insert(pending_cmds.size(), c);
		queued++;
	endfunction

	function automatic void load_cell(input int row, input int col,
			input logic [VAL_W-1:0] v);
		push_cmd(KIND_LOAD, v, col, $urandom_range(63), row, $urandom_range(63), 1'b0);
		was_loaded[row * MAX_SIDE + col] = 1'b1;
	endfunction

	// Fill any cell the clipped rectangle covers that was never loaded, then query
	function automatic void ask_rect(input int l, input int r, input int t, input int b,
			input bit hold);
		int rgt, bot, row, col;
		rgt = (r > gen_side - 1) ? gen_side - 1 : r;
		bot = (b > gen_side - 1) ? gen_side - 1 : b;
		for (row = t; row <= bot; row++)
			for (col = l; col <= rgt; col++)
				if (!was_loaded[row * MAX_SIDE + col])
					load_cell(row, col, VAL_W'($urandom_range(0, 32'h7FFF_FFFF)));
		push_cmd(KIND_QUERY, VAL_W'($urandom), l, r, t, b, hold);
	endfunction

	function automatic int unsigned pick_factor();
		case ($urandom_range(3))
			0: return 32'd1 << $urandom_range(30);
			1: return $urandom_range(2, 1000);
			2: return $urandom_range(32'h0001_0000, 32'h4000_0000);
			default: return 32'd1;
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] scaled(input int unsigned g);
		if ($urandom_range(7) == 0) return '0;
		if (g == 1) return VAL_W'($urandom);
		return VAL_W'(g * $urandom_range(1, 32'h7FFF_FFFF / g));
	endfunction

	// Load a small rectangle with multiples of one factor, keeping some cells loaded before, then query it
	function automatic void rect_burst();
		int cap, h, w, t0, l0, r_f, b_f, i, j;
		int unsigned g;
		cap = (gen_side < 4) ? gen_side : 4;
		if ($urandom_range(9) == 0) cap = (gen_side < 8) ? gen_side : 8;
		h  = $urandom_range(1, cap);
		w  = $urandom_range(1, cap);
		t0 = $urandom_range(0, gen_side - h);
		l0 = $urandom_range(0, gen_side - w);
		g  = pick_factor();
		for (i = 0; i < h; i++)
			for (j = 0; j < w; j++)
				if (!was_loaded[(t0 + i) * MAX_SIDE + l0 + j] || $urandom_range(3) != 0)
					load_cell(t0 + i, l0 + j, scaled(g));
		r_f = l0 + w - 1;
		b_f = t0 + h - 1;
		// run the far edges past the matrix now and then, to exercise clipping
		if (r_f == gen_side - 1 && $urandom_range(1) == 1) r_f = $urandom_range(r_f, 63);
		if (b_f == gen_side - 1 && $urandom_range(1) == 1) b_f = $urandom_range(b_f, 63);
		ask_rect(l0, r_f, t0, b_f, $urandom_range(19) == 0);
	endfunction

	// Stray loads, empty rectangles and lone cells
	function automatic void noise_cmd();
		int l, t;
		case ($urandom_range(3))
			0: load_cell($urandom_range(63), $urandom_range(63),
					VAL_W'($urandom_range(0, 32'h7FFF_FFFF)));
			1: begin
				l = $urandom_range(1, 63);
				push_cmd(KIND_QUERY, VAL_W'($urandom), l, $urandom_range(0, l - 1),
					$urandom_range(63), $urandom_range(63), 1'b0);
			end
			2: begin
				t = $urandom_range(1, 63);
				push_cmd(KIND_QUERY, VAL_W'($urandom), $urandom_range(63),
					$urandom_range(63), t, $urandom_range(0, t - 1), 1'b0);
			end
			default: begin
				if (gen_side < MAX_SIDE) begin
					push_cmd(KIND_QUERY, VAL_W'($urandom), $urandom_range(gen_side, 63),
						$urandom_range(63), $urandom_range(63), $urandom_range(63), 1'b0);
				end else begin
					l = $urandom_range(63);
					t = $urandom_range(63);
					ask_rect(l, l, t, t, 1'b0);
				end
			end
		endcase
	endfunction

	// Corners, all-ones value, zero cells and empty rectangles at side 64
	function automatic void directed_cmds();
		load_cell(0, 0, VAL_TOP);
		ask_rect(0, 0, 0, 0, 1'b0);
		load_cell(0, 1, '0);
		ask_rect(0, 1, 0, 0, 1'b0);
		load_cell(63, 63, '0);
		ask_rect(63, 63, 63, 63, 1'b0);
		load_cell(62, 62, 31'h4000_0000);
		load_cell(62, 63, 31'h2AAA_AAAA);
		load_cell(63, 62, 31'h7FFF_FFFE);
		ask_rect(62, 63, 62, 63, 1'b0);
		push_cmd(KIND_QUERY, VAL_TOP, 5, 4, 0, 0, 1'b0);
		push_cmd(KIND_QUERY, '0, 0, 0, 10, 9, 1'b0);
		push_cmd(KIND_QUERY, VAL_TOP, 63, 0, 63, 0, 1'b0);
		ask_rect(0, 1, 0, 0, 1'b1);
	endfunction

	// ---------------------------------------------------------------- driver

	always @(negedge clk) begin : driver
		cmd_t nxt;
		// hold the current beat until it is taken
		if (arst_n && !(start && !taken)) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct &&
					!(pending_cmds[0].hold && awaited_gcds.size() != 0)) begin
				nxt = pending_cmds.pop_front();
				kind   <= nxt.kind;
				value  <= nxt.value;
				left   <= nxt.left;
				right  <= nxt.right;
				top    <= nxt.top;
				bottom <= nxt.bottom;
				start  <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin : monitor
		answer_t want;
		cmd_t seen;
		if (arst_n) begin
			// check the result beat against the oldest answer
			if (done) begin
				if (awaited_gcds.size() == 0) begin
					$error("unexpected result beat: gcd %0d, empty_res %0b", gcd, empty_res);
					fails++;
				end else begin
					want = awaited_gcds.pop_front();
					if (gcd !== want.gcd) begin
						$error("gcd: expected %0d, got %0d", want.gcd, gcd);
						fails++;
					end
					if (empty_res !== want.is_empty) begin
						$error("empty_res: expected %0b, got %0b", want.is_empty, empty_res);
						fails++;
					end
				end
			end
			// predict from the command beat taken at this edge
			if (start && !busy) begin
				seen.kind   = kind;
				seen.value  = value;
				seen.left   = left;
				seen.right  = right;
				seen.top    = top;
				seen.bottom = bottom;
				seen.hold   = 1'b0;
				apply_cmd(seen);
			end
			taken <= start && !busy;
			// watchdog on cycles with no beat in either direction
			if (done || (start && !busy)) quiet = 0;
			else quiet++;
			if (quiet >= WATCH_LIMIT) begin
				$display("matrix_range_gcd_query_tb failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequencing

	task automatic settle();
		while (pending_cmds.size() != 0 || start || awaited_gcds.size() != 0)
			@(posedge clk);
		// let a trailing load finish before touching the register
		repeat (4) @(posedge clk);
	endtask

	task automatic write_side(input logic [SIDE_W-1:0] s);
		logic [31:0] word;
		word = $urandom;
		word[SIDE_W-1:0] = s;
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = {REG_SIDE, 2'b00};
		pwdata  = word;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		side_copy = s;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	initial begin : stimulus
		int p, sv;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (p = 0; p < PHASES; p++) begin
			// first phase runs on the reset side; later ones rewrite it while idle
			if (p != 0) begin
				settle();
				sv = (side_plan[p] < 0) ? $urandom_range(3, 63) : side_plan[p];
				write_side(SIDE_W'(sv));
			end
			gen_side = side_eff(int'(side_copy));
			idle_pct = idle_plan[p % 3];
			if (p == 0) directed_cmds();
			// clipped whole matrix and rectangles starting past the side
			if (gen_side <= 8) ask_rect(0, 63, 0, 63, 1'b0);
			if (gen_side < MAX_SIDE) begin
				push_cmd(KIND_QUERY, VAL_W'($urandom), gen_side, 63, 0, 63, 1'b0);
				push_cmd(KIND_QUERY, VAL_W'($urandom), 0, 63, gen_side, 63, 1'b0);
			end
			while (queued < (p + 1) * ITEMS / PHASES) begin
				if ($urandom_range(4) == 0) noise_cmd();
				else rect_burst();
			end
		end
		settle();
		repeat (20) @(posedge clk);
		if (fails == 0 && awaited_gcds.size() == 0) begin
			$display("matrix_range_gcd_query_tb passed");
		end else begin
			$display("matrix_range_gcd_query_tb failed");
		end
		$finish;
	end

endmodule
